@@ hdl/amp_pkg.sv @@
// ---------------------------------------------------------------------------
// amp_pkg
// Shared types and constants for the amicable pair / perfect number test.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package amp_pkg;

    localparam int IN_BITS  = 16;
    localparam int SUM_BITS = 18;
    localparam logic [SUM_BITS-1:0] SUM_MAX = 18'h3ffff;

    typedef struct packed {
        logic [IN_BITS-1:0] first_number;
        logic [IN_BITS-1:0] second_number;
    } t_request;

    typedef struct packed {
        logic [SUM_BITS-1:0] first_divisor_sum;
        logic [SUM_BITS-1:0] second_divisor_sum;
        logic                first_is_perfect;
        logic                pair_is_amicable;
    } t_result;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_status;

endpackage

`default_nettype wire

@@ hdl/amicable_pair_test.sv @@
// ---------------------------------------------------------------------------
// amicable_pair_test
// Proper divisor sums of two numbers by trial division, with perfect and
// amicable flags.
//
// Channel   Signals                       Transfer
// request   start, busy, i_request        rising edge with start && !busy
// result    o_done, o_result              rising edge ending the o_done cycle
//
// Each trial divisor d (2 up to floor(sqrt(n))+1) takes one run of the
// bit-serial divider, of width WIDTH = min(NUMBER_BITS, 16). busy is high
// from the transfer until o_done.
// Synchronous active-low reset returns the sequencer to idle.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amicable_pair_test #(
    parameter int NUMBER_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire amp_pkg::t_request i_request,
    output logic               busy,
    output logic               o_done,
    output amp_pkg::t_result   o_result
);

    localparam int USE_BITS = (NUMBER_BITS < amp_pkg::IN_BITS) ? NUMBER_BITS
                                                                : amp_pkg::IN_BITS;
    localparam int SUM_W    = USE_BITS + 3;
    localparam int CW       = (SUM_W > amp_pkg::SUM_BITS) ? SUM_W : amp_pkg::SUM_BITS;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SETUP  = 5'b00010,
        S_DIV    = 5'b00100,
        S_CHECK  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_which, n_which;
    logic [USE_BITS-1:0]  r_d, n_d;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [SUM_W-1:0]     r_held, n_held;
    logic [USE_BITS-1:0]  r_a, n_a;
    logic [USE_BITS-1:0]  r_b, n_b;
    logic                 r_done, n_done;
    amp_pkg::t_result     r_result, n_result;

    logic                 w_div_start;
    logic [USE_BITS-1:0]  w_div_divisor;
    logic [USE_BITS-1:0]  w_cur;
    logic [USE_BITS-1:0]  w_quo;
    amp_pkg::t_div_status w_div_status;

    logic [CW-1:0]        w_first_ext, w_second_ext;
    logic [amp_pkg::SUM_BITS-1:0] w_first_clamp, w_second_clamp;

    assign w_cur = r_which ? r_b : r_a;

    amp_serial_div #(
        .WIDTH (USE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_cur),
        .i_divisor  (w_div_divisor),
        .o_quotient (w_quo),
        .o_status   (w_div_status)
    );

    assign w_first_ext    = CW'(r_held);
    assign w_second_ext   = CW'(r_sum);
    assign w_first_clamp  = (w_first_ext > CW'(amp_pkg::SUM_MAX)) ? amp_pkg::SUM_MAX
                                                                  : w_first_ext[amp_pkg::SUM_BITS-1:0];
    assign w_second_clamp = (w_second_ext > CW'(amp_pkg::SUM_MAX)) ? amp_pkg::SUM_MAX
                                                                   : w_second_ext[amp_pkg::SUM_BITS-1:0];

    always_comb begin
        n_state       = r_state;
        n_which       = r_which;
        n_d           = r_d;
        n_sum         = r_sum;
        n_held        = r_held;
        n_a           = r_a;
        n_b           = r_b;
        n_done        = 1'b0;
        n_result      = r_result;
        w_div_start   = 1'b0;
        w_div_divisor = r_d;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_a     = i_request.first_number[USE_BITS-1:0];
                    n_b     = i_request.second_number[USE_BITS-1:0];
                    n_which = 1'b0;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (w_cur < USE_BITS'(2)) begin
                    n_sum   = '0;
                    n_state = S_FINISH;
                end else begin
                    n_sum         = SUM_W'(1);
                    n_d           = USE_BITS'(2);
                    w_div_start   = 1'b1;
                    w_div_divisor = USE_BITS'(2);
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_status.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // quotient below divisor means d*d > n
                if (w_quo < r_d) begin
                    n_state = S_FINISH;
                end else begin
                    if (w_div_status.rem_zero) begin
                        n_sum = r_sum + SUM_W'(r_d)
                              + ((w_quo != r_d) ? SUM_W'(w_quo) : '0);
                    end
                    n_d           = USE_BITS'(r_d + 1'b1);
                    w_div_start   = 1'b1;
                    w_div_divisor = USE_BITS'(r_d + 1'b1);
                    n_state       = S_DIV;
                end
            end
            S_FINISH: begin
                if (!r_which) begin
                    n_held  = r_sum;
                    n_which = 1'b1;
                    n_state = S_SETUP;
                end else begin
                    n_result.first_divisor_sum  = w_first_clamp;
                    n_result.second_divisor_sum = w_second_clamp;
                    n_result.first_is_perfect   = (r_a != '0) && (r_held == SUM_W'(r_a));
                    n_result.pair_is_amicable   = (r_a != '0) && (r_b != '0)
                                                && (SUM_W'(r_a) == r_sum)
                                                && (SUM_W'(r_b) == r_held);
                    n_done  = 1'b1;
                    n_which = 1'b0;
                    n_d     = '0;
                    n_sum   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_which <= 1'b0;
            r_d     <= '0;
            r_sum   <= '0;
            r_held  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_which <= n_which;
            r_d     <= n_d;
            r_sum   <= n_sum;
            r_held  <= n_held;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTH
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request transfer");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_perfect_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.first_is_perfect)
            |-> (o_result.first_divisor_sum == amp_pkg::SUM_BITS'(r_a)))
        else $error("perfect flag disagrees with divisor sum");

    a_divisor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_d > USE_BITS'(1)))
        else $error("trial divisor below two");
`endif

endmodule

`default_nettype wire

@@ hdl/amp_serial_div.sv @@
// ---------------------------------------------------------------------------
// amp_serial_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amp_serial_div #(
    parameter int WIDTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [WIDTH-1:0]   i_dividend,
    input  wire logic [WIDTH-1:0]   i_divisor,
    output logic      [WIDTH-1:0]   o_quotient,
    output amp_pkg::t_div_status    o_status
);

    localparam int CNT_BITS = $clog2(WIDTH);

    logic [WIDTH-1:0]    r_rem;
    logic [WIDTH-1:0]    r_quo;
    logic [WIDTH-1:0]    r_dvs;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_run;
    logic                r_done;

    logic [WIDTH:0]      w_shift;
    logic                w_ge;
    logic [WIDTH:0]      w_diff;

    assign w_shift = {r_rem, r_quo[WIDTH-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(WIDTH - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= w_ge ? w_diff[WIDTH-1:0] : w_shift[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], w_ge};
        end
    end

    assign o_quotient        = r_quo;
    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem == '0);

endmodule

`default_nettype wire
